### hdl/osc_message_deframer_macros.svh
// ----------------------------------------------------------------------------
// OSC message deframer: assertion macros
// Shared concurrent-assertion shorthands; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef OSC_MESSAGE_DEFRAMER_MACROS_SVH
`define OSC_MESSAGE_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define OMD_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define OMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/omd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omd_pkg
// Types and constants shared by the OSC message deframer modules.
// ----------------------------------------------------------------------------
package omd_pkg;

  // Datagram and tag limits
  localparam int MAX_DATAGRAM_BYTES = 4096;
  localparam int MAX_TYPE_TAGS      = 64;
  localparam int LEN_W              = 13;
  localparam int POS_W              = LEN_W;
  localparam int TAG_IDX_W          = $clog2(MAX_TYPE_TAGS);
  localparam int TAG_CNT_W          = $clog2(MAX_TYPE_TAGS + 1);
  localparam int ARG_W              = 6;
  localparam int WORD_W             = 32;
  localparam int WORD_KEEP_W        = 24;

  // Queue and output buffer sizes (powers of two, pointers wrap naturally)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OBUF_DEPTH  = 4;
  localparam int OPTR_W      = $clog2(OBUF_DEPTH);
  localparam int OCNT_W      = $clog2(OBUF_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_INT    = 8'h69;
  localparam logic [7:0] CH_FLOAT  = 8'h66;
  localparam logic [7:0] CH_STRING = 8'h73;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SEEK_SLASH = 3'd0,
    PH_ADDRESS    = 3'd1,
    PH_SEEK_COMMA = 3'd2,
    PH_TAGS       = 3'd3,
    PH_ALIGN      = 3'd4,
    PH_ARGS       = 3'd5,
    PH_STRING     = 3'd6,
    PH_PAD        = 3'd7
  } phase_t;

  // Token kinds on the result channel
  typedef enum logic [2:0] {
    TK_ADDR_BYTE  = 3'd0,
    TK_TYPE_TAG   = 3'd1,
    TK_INT_WORD   = 3'd2,
    TK_FLOAT_WORD = 3'd3,
    TK_STR_BYTE   = 3'd4,
    TK_STR_END    = 3'd5,
    TK_MSG_END    = 3'd6
  } tok_kind_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] pos_lo;
    logic       restart;
    logic       parse_en;
    logic       ended;
  } entry_t;

  // One result token
  typedef struct packed {
    tok_kind_t          kind;
    logic [WORD_W-1:0]  value;
    logic [ARG_W-1:0]   arg;
  } tok_t;

endpackage
`default_nettype wire

### hdl/omd_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// OSC message deframer channels
// Valid/ready interfaces for the datagram byte input and the token output.
// ----------------------------------------------------------------------------

// Datagram byte channel
interface omd_in_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               data_byte;
  logic [omd_pkg::LEN_W-1:0] datagram_length;
  logic                     first_byte;
  logic                     last_byte;

  modport source (output valid, output data_byte, output datagram_length,
                  output first_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input datagram_length,
                  input first_byte, input last_byte, output ready);
endinterface

// Token channel
interface omd_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                token_kind;
  logic [omd_pkg::WORD_W-1:0] token_value;
  logic [omd_pkg::ARG_W-1:0]  argument_number;

  modport source (output valid, output token_kind, output token_value,
                  output argument_number, input ready);
  modport sink   (input valid, input token_kind, input token_value,
                  input argument_number, output ready);
endinterface
`default_nettype wire

### hdl/omd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omd_front
// Tracks datagram framing and byte position, classifies each accepted byte.
// ----------------------------------------------------------------------------
module omd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  omd_in_if.sink                in_ch,
  input  wire logic             q_full,
  output logic                  push,
  output omd_pkg::entry_t       push_entry
);

  logic                       open_r, open_nxt;
  logic [omd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       accept;
  logic                       open_eff;
  logic [omd_pkg::POS_W-1:0]  pos_eff;
  logic [omd_pkg::POS_W:0]    pos_inc;
  logic                       len_ok;
  logic                       ended;

  // Take a byte whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Framing: a first byte opens (or reopens) a datagram at position zero
  always_comb begin
    open_eff = in_ch.first_byte || open_r;
    pos_eff  = in_ch.first_byte ? '0 : pos_r;
    pos_inc  = {1'b0, pos_eff} + (omd_pkg::POS_W + 1)'(1);
    len_ok   = (in_ch.datagram_length != '0) &&
               (in_ch.datagram_length[1:0] == 2'b00) &&
               (in_ch.datagram_length <= omd_pkg::LEN_W'(omd_pkg::MAX_DATAGRAM_BYTES));
    ended    = in_ch.last_byte || (pos_inc >= {1'b0, in_ch.datagram_length});

    push                 = accept && open_eff;
    push_entry.data_byte = in_ch.data_byte;
    push_entry.pos_lo    = pos_eff[1:0];
    push_entry.restart   = in_ch.first_byte;
    push_entry.parse_en  = len_ok && (pos_eff < in_ch.datagram_length);
    push_entry.ended     = ended;

    open_nxt = open_r;
    pos_nxt  = pos_r;
    if (push) begin
      pos_nxt  = pos_inc[omd_pkg::POS_W-1:0];
      open_nxt = !ended;
    end
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      open_r <= open_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/omd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omd_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module omd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire omd_pkg::entry_t   push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output omd_pkg::entry_t        head_entry
);

  omd_pkg::entry_t              slots [omd_pkg::QUEUE_DEPTH];
  logic [omd_pkg::QPTR_W-1:0]   wr_r, rd_r;
  logic [omd_pkg::QCNT_W-1:0]   cnt_r;

  assign full       = (cnt_r == omd_pkg::QCNT_W'(omd_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slots[rd_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_r] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + omd_pkg::QPTR_W'(push);
      rd_r  <= rd_r + omd_pkg::QPTR_W'(pop);
      cnt_r <= cnt_r + omd_pkg::QCNT_W'(push) - omd_pkg::QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

### hdl/omd_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "osc_message_deframer_macros.svh"
// ----------------------------------------------------------------------------
// omd_back
// Message parser: phase machine, tag store and a small token output buffer.
// ----------------------------------------------------------------------------
module omd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire omd_pkg::entry_t  head_entry,
  output logic                  pop,
  omd_out_if.source             out_ch
);

  omd_pkg::phase_t                phase_r, phase_nxt;
  logic [omd_pkg::TAG_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [omd_pkg::TAG_CNT_W-1:0]  cur_r, cur_nxt, cur_inc;
  logic [omd_pkg::WORD_KEEP_W-1:0] word_r, word_nxt;
  logic [1:0]                     wcnt_r, wcnt_nxt;
  logic [omd_pkg::WORD_W-1:0]     word_full;

  logic [7:0]                     tag_mem [omd_pkg::MAX_TYPE_TAGS];
  logic [7:0]                     tag_q_r;
  logic                           tag_we;
  logic [omd_pkg::TAG_IDX_W-1:0]  tag_raddr;

  omd_pkg::tok_t                  tok_a, tok_b, tok_e, slot0, slot1;
  logic                           va, vb, ve, v0, v1;
  logic                           step;

  omd_pkg::tok_t                  obuf [omd_pkg::OBUF_DEPTH];
  logic [omd_pkg::OPTR_W-1:0]     owr_r, ord_r;
  logic [omd_pkg::OCNT_W-1:0]     ocnt_r;
  logic [1:0]                     n_push;
  logic                           out_pop;

  // Step an item only when the buffer can take two tokens
  assign step      = head_valid &&
                     (ocnt_r <= omd_pkg::OCNT_W'(omd_pkg::OBUF_DEPTH - 2));
  assign pop       = step;
  assign cur_inc   = cur_r + omd_pkg::TAG_CNT_W'(1);
  assign word_full = {word_r, head_entry.data_byte};
  assign tag_raddr = cur_nxt[omd_pkg::TAG_IDX_W-1:0];

  // Phase machine: next state and tokens
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    word_nxt  = word_r;
    wcnt_nxt  = wcnt_r;
    tag_we    = 1'b0;
    va        = 1'b0;
    vb        = 1'b0;
    ve        = 1'b0;
    tok_a     = '0;
    tok_b     = '0;
    tok_e     = '0;
    tok_b.kind = omd_pkg::TK_MSG_END;
    tok_e.kind = omd_pkg::TK_MSG_END;

    if (step) begin
      // New datagram abandons any message in progress
      if (head_entry.restart) begin
        phase_nxt = omd_pkg::PH_SEEK_SLASH;
        cnt_nxt   = '0;
        cur_nxt   = '0;
        word_nxt  = '0;
        wcnt_nxt  = '0;
      end

      if (head_entry.parse_en) begin
        // Alignment phases resolve on a 4-byte boundary before the byte is used
        if (phase_nxt == omd_pkg::PH_ALIGN && head_entry.pos_lo == 2'b00) begin
          phase_nxt = omd_pkg::PH_ARGS;
        end else if (phase_nxt == omd_pkg::PH_PAD && head_entry.pos_lo == 2'b00) begin
          phase_nxt = omd_pkg::PH_SEEK_SLASH;
        end
        if (phase_nxt == omd_pkg::PH_ARGS && tag_q_r == omd_pkg::CH_STRING) begin
          phase_nxt = omd_pkg::PH_STRING;
        end

        case (phase_nxt)
          omd_pkg::PH_SEEK_SLASH: begin
            if (head_entry.data_byte == omd_pkg::CH_SLASH) begin
              cnt_nxt     = '0;
              cur_nxt     = '0;
              word_nxt    = '0;
              wcnt_nxt    = '0;
              phase_nxt   = omd_pkg::PH_ADDRESS;
              va          = 1'b1;
              tok_a.kind  = omd_pkg::TK_ADDR_BYTE;
              tok_a.value = omd_pkg::WORD_W'(head_entry.data_byte);
            end
          end
          omd_pkg::PH_ADDRESS: begin
            if (head_entry.data_byte == omd_pkg::CH_NUL) begin
              phase_nxt = omd_pkg::PH_SEEK_COMMA;
            end else begin
              va          = 1'b1;
              tok_a.kind  = omd_pkg::TK_ADDR_BYTE;
              tok_a.value = omd_pkg::WORD_W'(head_entry.data_byte);
            end
          end
          omd_pkg::PH_SEEK_COMMA: begin
            if (head_entry.data_byte == omd_pkg::CH_COMMA) begin
              phase_nxt = omd_pkg::PH_TAGS;
            end
          end
          omd_pkg::PH_TAGS: begin
            if (head_entry.data_byte == omd_pkg::CH_NUL) begin
              // Empty tag list closes the message here
              if (cnt_r == '0) begin
                va         = 1'b1;
                tok_a.kind = omd_pkg::TK_MSG_END;
                phase_nxt  = omd_pkg::PH_PAD;
              end else begin
                phase_nxt = omd_pkg::PH_ALIGN;
              end
            end else if (cnt_r < omd_pkg::TAG_CNT_W'(omd_pkg::MAX_TYPE_TAGS)) begin
              tag_we      = 1'b1;
              va          = 1'b1;
              tok_a.kind  = omd_pkg::TK_TYPE_TAG;
              tok_a.value = omd_pkg::WORD_W'(head_entry.data_byte);
              tok_a.arg   = cnt_r[omd_pkg::ARG_W-1:0];
              cnt_nxt     = cnt_r + omd_pkg::TAG_CNT_W'(1);
            end
          end
          omd_pkg::PH_ARGS: begin
            if (wcnt_r != 2'd3) begin
              word_nxt = word_full[omd_pkg::WORD_KEEP_W-1:0];
              wcnt_nxt = wcnt_r + 2'd1;
            end else begin
              if (tag_q_r == omd_pkg::CH_INT) begin
                va          = 1'b1;
                tok_a.kind  = omd_pkg::TK_INT_WORD;
                tok_a.value = word_full;
                tok_a.arg   = cur_r[omd_pkg::ARG_W-1:0];
              end else if (tag_q_r == omd_pkg::CH_FLOAT) begin
                va          = 1'b1;
                tok_a.kind  = omd_pkg::TK_FLOAT_WORD;
                tok_a.value = word_full;
                tok_a.arg   = cur_r[omd_pkg::ARG_W-1:0];
              end
              word_nxt = '0;
              wcnt_nxt = '0;
              cur_nxt  = cur_inc;
              if (cur_inc >= cnt_r) begin
                vb        = 1'b1;
                phase_nxt = omd_pkg::PH_SEEK_SLASH;
              end
            end
          end
          omd_pkg::PH_STRING: begin
            va        = 1'b1;
            tok_a.arg = cur_r[omd_pkg::ARG_W-1:0];
            if (head_entry.data_byte != omd_pkg::CH_NUL) begin
              tok_a.kind  = omd_pkg::TK_STR_BYTE;
              tok_a.value = omd_pkg::WORD_W'(head_entry.data_byte);
            end else begin
              tok_a.kind = omd_pkg::TK_STR_END;
              cur_nxt    = cur_inc;
              if (cur_inc >= cnt_r) begin
                vb        = 1'b1;
                phase_nxt = omd_pkg::PH_PAD;
              end else begin
                phase_nxt = omd_pkg::PH_ALIGN;
              end
            end
          end
          omd_pkg::PH_ALIGN, omd_pkg::PH_PAD: begin
            // still waiting for the boundary
          end
          default: begin
          end
        endcase
      end

      // End of datagram closes an open message
      if (head_entry.ended) begin
        ve        = !(phase_nxt inside {omd_pkg::PH_SEEK_SLASH, omd_pkg::PH_PAD});
        phase_nxt = omd_pkg::PH_SEEK_SLASH;
        cnt_nxt   = '0;
        cur_nxt   = '0;
        word_nxt  = '0;
        wcnt_nxt  = '0;
      end
    end
  end

  // Pack up to two tokens in order
  always_comb begin
    v0     = va || vb || ve;
    slot0  = va ? tok_a : (vb ? tok_b : tok_e);
    v1     = (va && vb) || ((va || vb) && ve);
    slot1  = (va && vb) ? tok_b : tok_e;
    n_push = {1'b0, v0} + {1'b0, v1};
  end

  // Phase register and message counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= omd_pkg::PH_SEEK_SLASH;
      cnt_r   <= '0;
      cur_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  // Partial argument word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Tag store: written at the tag count, read ahead at the next cursor
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[cnt_r[omd_pkg::TAG_IDX_W-1:0]] <= head_entry.data_byte;
    end
    tag_q_r <= tag_mem[tag_raddr];
  end

  // Output buffer storage
  always_ff @(posedge clk) begin
    if (v0) begin
      obuf[owr_r] <= slot0;
    end
    if (v1) begin
      obuf[owr_r + omd_pkg::OPTR_W'(1)] <= slot1;
    end
  end

  // Output buffer pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_r + omd_pkg::OPTR_W'(n_push);
      ord_r  <= ord_r + omd_pkg::OPTR_W'(out_pop);
      ocnt_r <= ocnt_r + omd_pkg::OCNT_W'(n_push) - omd_pkg::OCNT_W'(out_pop);
    end
  end

  // Result channel
  assign out_ch.valid           = (ocnt_r != '0);
  assign out_ch.token_kind      = obuf[ord_r].kind;
  assign out_ch.token_value     = obuf[ord_r].value;
  assign out_ch.argument_number = obuf[ord_r].arg;
  assign out_pop                = out_ch.valid && out_ch.ready;

  // Checks
  `OMD_ASSERT_HOLDS(a_cursor_in_range, (phase_r == omd_pkg::PH_ARGS) || (phase_r == omd_pkg::PH_STRING), cur_r < cnt_r, "argument phase with cursor past tag count")
  `OMD_ASSERT_HOLDS(a_word_idle, phase_r != omd_pkg::PH_ARGS, wcnt_r == 2'd0, "partial word left outside argument phase")
  `OMD_ASSERT_HOLDS(a_obuf_bound, 1'b1, ocnt_r <= omd_pkg::OCNT_W'(omd_pkg::OBUF_DEPTH), "output buffer overfilled")
  `OMD_ASSERT_NEXT(a_msg_end_closes, (v0 && slot0.kind == omd_pkg::TK_MSG_END) || (v1 && slot1.kind == omd_pkg::TK_MSG_END), (phase_r == omd_pkg::PH_SEEK_SLASH) || (phase_r == omd_pkg::PH_PAD), "parser still in message after message end")

endmodule
`default_nettype wire

### hdl/osc_message_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc_message_deframer
// Splits OSC datagrams, one byte per item, into address, tag and argument
// tokens.
//
//   Channel   Dir  Handshake       Payload
//   in_ch     in   valid / ready   data_byte, datagram_length, first/last_byte
//   out_ch    out  valid / ready   token_kind, token_value, argument_number
//
// Takes one byte per cycle while the byte queue has room; each byte yields
// zero, one or two tokens and the token buffer drains one token per cycle
// while out_ch is ready. A token is registered in the byte queue, then in the
// token buffer, before it is offered on out_ch.
// Reset is synchronous; the tag store is not cleared and needs no sweep.
// A stalled out_ch fills the token buffer; the parser holds once fewer than
// two of its four slots are free, and the four-entry byte queue then fills
// before in_ch.ready drops.
// ----------------------------------------------------------------------------
module osc_message_deframer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  omd_in_if.sink     in_ch,
  omd_out_if.source  out_ch
);

  logic             q_full;
  logic             push;
  omd_pkg::entry_t  push_entry;
  logic             pop;
  logic             head_valid;
  omd_pkg::entry_t  head_entry;

  // Framing and byte classification
  omd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Byte queue
  omd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Parser and token output
  omd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
